[src/oahm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and sizes for the open-addressing hash map.
// No dependencies; every other file of the block imports this package.
package oahm_pkg;

    // Table size; must be a power of two, from 2 up to 2^20 slots
    localparam int SLOTS = 16384;
    localparam int IDX_W = $clog2(SLOTS);
    // Probe counter also holds SLOTS itself
    localparam int CNT_W = IDX_W + 1;

    // Field widths on the stream ports
    localparam int CMD_W = 2;
    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int ST_W = 2;
    localparam int IN_DATA_W = KEY_W + VAL_W;
    localparam int OUT_DATA_W = VAL_W;

    // Golden-ratio multiplier, split into 32-bit halves for the shared multiplier
    localparam int MUL_W = 32;
    localparam logic [MUL_W-1:0] GOLDEN_LO = 32'h7f4a7c15;
    localparam logic [MUL_W-1:0] GOLDEN_HI = 32'h9e3779b9;

    // Command codes on s_tuser
    localparam logic [CMD_W-1:0] CMD_GET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Status codes on m_tuser
    localparam logic [ST_W-1:0] ST_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd3;

    // Work classes decided by the front end
    typedef enum logic [2:0] {
        OP_GET,
        OP_PUT,
        OP_CLEAR,
        OP_NOP,
        OP_ZERO
    } op_kind_t;

    // One queued word between front and back
    typedef struct packed {
        op_kind_t               kind;
        logic [KEY_W-1:0]       key;
        logic [VAL_W-1:0]       value;
        logic [IDX_W-1:0]       home;
    } queue_entry_t;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

endpackage

[src/oahm_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input words, classifies them and computes the home slot.
// Depends on oahm_pkg; feeds oahm_queue.
module oahm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [oahm_pkg::IN_DATA_W-1:0] s_tdata,   // key [63:0], value [127:64]
    input  logic [oahm_pkg::CMD_W-1:0]     s_tuser,   // cmd [1:0]
    input  logic                          init_busy,
    input  logic                          q_full,
    output logic                          q_push,
    output oahm_pkg::queue_entry_t        q_entry
);
    import oahm_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } front_state_t;

    front_state_t         state_reg, state_next;
    logic [1:0]           step_reg, step_next;
    op_kind_t             kind_reg, kind_next;
    logic [KEY_W-1:0]     key_reg;
    logic [VAL_W-1:0]     value_reg;
    logic [IDX_W-1:0]     acc_reg, acc_next;

    logic                 accept;
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [2*MUL_W-1:0]   prod;
    logic [IDX_W-1:0]     acc_sum;
    logic                 last_step;

    assign s_tready = (state_reg == F_IDLE) && !init_busy;
    assign accept = s_tvalid && s_tready;
    assign last_step = (state_reg == F_HASH) && (step_reg == 2'd2);

    // Pick partial-product operands: lo*lo, lo*hi, hi*lo
    always_comb begin
        unique case (step_reg)
            2'd0: begin
                mul_a = key_reg[MUL_W-1:0];
                mul_b = GOLDEN_LO;
            end
            2'd1: begin
                mul_a = key_reg[MUL_W-1:0];
                mul_b = GOLDEN_HI;
            end
            default: begin
                mul_a = key_reg[KEY_W-1:MUL_W];
                mul_b = GOLDEN_LO;
            end
        endcase
    end

    // Sum index bits: upper word of lo*lo, lower word of the cross products
    assign prod = mul_a * mul_b;
    assign acc_sum = (step_reg == 2'd0) ? prod[MUL_W +: IDX_W]
                                        : IDX_W'(acc_reg + prod[IDX_W-1:0]);

    // Classify, step the hash and hand words to the queue
    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        kind_next = kind_reg;
        acc_next = acc_reg;
        q_push = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    step_next = 2'd0;
                    unique case (s_tuser)
                        CMD_GET, CMD_PUT: begin
                            if (s_tdata[KEY_W-1:0] == '0) begin
                                kind_next = OP_ZERO;
                                state_next = F_PUSH;
                            end else begin
                                kind_next = (s_tuser == CMD_GET) ? OP_GET : OP_PUT;
                                state_next = F_HASH;
                            end
                        end
                        CMD_CLEAR: begin
                            kind_next = OP_CLEAR;
                            state_next = F_PUSH;
                        end
                        default: begin
                            kind_next = OP_NOP;
                            state_next = F_PUSH;
                        end
                    endcase
                end
            end
            F_HASH: begin
                acc_next = acc_sum;
                if (last_step) begin
                    if (!q_full) begin
                        q_push = 1'b1;
                        state_next = F_IDLE;
                    end else begin
                        state_next = F_PUSH;
                    end
                end else begin
                    step_next = step_reg + 2'd1;
                end
            end
            F_PUSH: begin
                if (!q_full) begin
                    q_push = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    assign q_entry.kind = kind_reg;
    assign q_entry.key = key_reg;
    assign q_entry.value = value_reg;
    assign q_entry.home = last_step ? acc_sum : acc_reg;

    // Hold state and step count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            step_reg <= 2'd0;
            kind_reg <= OP_NOP;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            kind_reg <= kind_next;
        end
    end

    // Capture the word and the running hash
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg <= s_tdata[KEY_W-1:0];
            value_reg <= s_tdata[IN_DATA_W-1:KEY_W];
        end
        acc_reg <= acc_next;
    end

endmodule

[src/oahm_queue.sv]
`timescale 1ns / 1ps
// Short first-in first-out queue of classified words between front and back.
// Depends on oahm_pkg for the entry type and depth.
module oahm_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  oahm_pkg::queue_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output oahm_pkg::queue_entry_t pop_entry,
    output logic                   empty
);
    import oahm_pkg::*;

    queue_entry_t        entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_push, do_pop;

    assign full = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign pop_entry = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[src/oahm_back.sv]
`timescale 1ns / 1ps
// Back end: slot memory, linear probe engine, clearing sweep and result register.
// Depends on oahm_pkg; drains oahm_queue.
module oahm_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    input  oahm_pkg::queue_entry_t         q_entry,
    output logic                           q_pop,
    output logic                           init_busy,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [oahm_pkg::OUT_DATA_W-1:0] m_tdata,  // read_value [63:0]
    output logic [oahm_pkg::ST_W-1:0]       m_tuser   // status [1:0]
);
    import oahm_pkg::*;

    typedef enum logic [1:0] {
        B_INIT,
        B_IDLE,
        B_PROBE,
        B_CLEAR
    } back_state_t;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] ALL_PROBED = CNT_W'(SLOTS);

    slot_t               slot_mem [SLOTS];
    slot_t               rd_data_reg;

    back_state_t         state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    op_kind_t            kind_reg, kind_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    value_reg, value_next;
    logic                m_valid_reg;
    logic [VAL_W-1:0]    m_data_reg;
    logic [ST_W-1:0]     m_user_reg;

    logic                mem_we, mem_re;
    logic [IDX_W-1:0]    mem_waddr, mem_raddr;
    slot_t               mem_wdata;
    logic                out_set;
    logic [VAL_W-1:0]    out_value;
    logic [ST_W-1:0]     out_status;
    logic                out_free;
    logic [IDX_W-1:0]    idx_step;

    assign init_busy = (state_reg == B_INIT);
    assign out_free = !m_valid_reg || m_tready;
    assign idx_step = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    // Sequence sweeps and probes
    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        kind_next = kind_reg;
        key_next = key_reg;
        value_next = value_reg;
        mem_we = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '0;
        mem_re = 1'b0;
        mem_raddr = idx_reg;
        q_pop = 1'b0;
        out_set = 1'b0;
        out_value = '0;
        out_status = ST_OK;
        unique case (state_reg)
            B_INIT, B_CLEAR: begin
                // Empty one slot a cycle
                mem_we = 1'b1;
                idx_next = idx_step;
                if (idx_reg == LAST_IDX) begin
                    state_next = B_IDLE;
                    out_set = (state_reg == B_CLEAR);
                end
            end
            B_IDLE: begin
                if (!q_empty && out_free) begin
                    q_pop = 1'b1;
                    kind_next = q_entry.kind;
                    key_next = q_entry.key;
                    value_next = q_entry.value;
                    unique case (q_entry.kind)
                        OP_GET, OP_PUT: begin
                            mem_re = 1'b1;
                            mem_raddr = q_entry.home;
                            idx_next = q_entry.home;
                            cnt_next = CNT_W'(1);
                            state_next = B_PROBE;
                        end
                        OP_CLEAR: begin
                            idx_next = '0;
                            state_next = B_CLEAR;
                        end
                        OP_ZERO: begin
                            out_set = 1'b1;
                            out_status = ST_ZERO;
                        end
                        default: begin
                            out_set = 1'b1;
                        end
                    endcase
                end
            end
            B_PROBE: begin
                // Check the slot just read; read the next one while walking on
                priority if (!rd_data_reg.used || rd_data_reg.key == key_reg) begin
                    out_set = 1'b1;
                    state_next = B_IDLE;
                    if (kind_reg == OP_GET) begin
                        out_status = rd_data_reg.used ? ST_OK : ST_MISS;
                        out_value = rd_data_reg.used ? rd_data_reg.value : '0;
                    end else begin
                        mem_we = 1'b1;
                        mem_wdata = '{used: 1'b1, key: key_reg, value: value_reg};
                    end
                end else if (cnt_reg == ALL_PROBED) begin
                    out_set = 1'b1;
                    out_status = (kind_reg == OP_GET) ? ST_MISS : ST_FULL;
                    state_next = B_IDLE;
                end else begin
                    mem_re = 1'b1;
                    mem_raddr = idx_step;
                    idx_next = idx_step;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Hold state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_INIT;
            idx_reg <= '0;
            cnt_reg <= '0;
            kind_reg <= OP_NOP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            kind_reg <= kind_next;
            if (out_set) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture payload of the word in work and of the result
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        value_reg <= value_next;
        if (out_set) begin
            m_data_reg <= out_value;
            m_user_reg <= out_status;
        end
    end

    // Slot memory: one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_user_reg;

endmodule

[src/open_addressing_hash_map_top.sv]
`timescale 1ns / 1ps
// Top level of the open-addressing hash map with linear probing.
// Depends on oahm_pkg, oahm_front, oahm_queue and oahm_back.
//
//   channel  dir  tdata                          tuser
//   s_       in   key [63:0], value [127:64]     cmd [1:0]: get, put, clear
//   m_       out  read_value [63:0]              status [1:0]: ok, miss, full, zero key
//
// In the front end a get or put is accepted, then takes three steps of the
// shared 32x32 multiplier that forms the home slot; the back end then issues the home
// read and probes one slot per cycle; the slot memory has a write and a read port.
// Clear, and the sweep after reset, write one slot a cycle across all SLOTS slots;
// s_tready stays low during the sweep after reset.
// A two-word queue lets the front hash the next word while the back probes;
// a stalled m_ side holds the result register and the queue fills behind it.
module open_addressing_hash_map_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [oahm_pkg::IN_DATA_W-1:0]  s_tdata,  // key [63:0], value [127:64]
    input  logic [oahm_pkg::CMD_W-1:0]      s_tuser,  // cmd [1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [oahm_pkg::OUT_DATA_W-1:0] m_tdata,  // read_value [63:0]
    output logic [oahm_pkg::ST_W-1:0]       m_tuser   // status [1:0]
);
    import oahm_pkg::*;

    logic         init_busy;
    logic         q_full, q_empty, q_push, q_pop;
    queue_entry_t push_entry, pop_entry;

    oahm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .init_busy (init_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    oahm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    oahm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_entry   (pop_entry),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[src/oahm_monitor.sv]
`timescale 1ns / 1ps
// Port-level assertions for the hash map top level, bound in below.
// Depends on oahm_pkg and open_addressing_hash_map_top.
module oahm_monitor (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [oahm_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [oahm_pkg::ST_W-1:0]       m_tuser
);
    import oahm_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only a hit carries a value
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_MISS || m_tuser == ST_FULL || m_tuser == ST_ZERO)
        |-> m_tdata == '0)
        else $error("non-hit result with non-zero value");

    // Table sweep after reset keeps the input closed
    a_init_closed: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !s_tready)
        else $error("input open during reset sweep");

    // Front end takes one word at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // Nothing comes out in the first cycle after reset
    a_quiet_after_reset: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_tvalid)
        else $error("result presented straight after reset");

endmodule

bind open_addressing_hash_map_top oahm_monitor u_monitor (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
